// ===== hdl/spd_pkg.sv =====
// ----------------------------------------------------------------------------
// spd_pkg
// Shared types, constants and the byte-wise crc step for the stx packet
// deframer.
// ----------------------------------------------------------------------------
package spd_pkg;

	localparam int BYTE_W   = 8;
	localparam int ADDR_W   = 7;
	localparam int CRC_W    = 16;
	localparam int POS_W    = 9;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W    = 16;

	localparam logic [BYTE_W-1:0] START_BYTE_DEF = 8'd127;

	localparam logic [POS_W-1:0] FRAME_OVERHEAD = 9'd5;
	localparam logic [POS_W-1:0] HEADER_LEN     = 9'd3;
	localparam logic [POS_W-1:0] POS_ADDR       = 9'd1;
	localparam logic [POS_W-1:0] POS_LEN        = 9'd2;
	localparam logic [POS_W-1:0] POS_MAX        = 9'd260;

	localparam logic [ADDR_W-1:0] DEV_ADDR_RST = 7'd0;
	localparam logic [CRC_W-1:0]  CRC_SEED_RST = 16'hFFFF;
	localparam logic [CRC_W-1:0]  CRC_POLY_RST = 16'h8005;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEV_ADDR = 2'd0,
		REG_CRC_SEED = 2'd1,
		REG_CRC_POLY = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		FS_OK         = 2'd0,
		FS_WRONG_ADDR = 2'd1,
		FS_BAD_CRC    = 2'd2
	} frame_status_t;

	// msb-first crc-16 over one byte, implicit top bit
	function automatic logic [CRC_W-1:0] crc_update(
		input logic [CRC_W-1:0]  crc_in,
		input logic [BYTE_W-1:0] data,
		input logic [CRC_W-1:0]  poly
	);
		logic [CRC_W-1:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int i = 0; i < BYTE_W; i++) begin
			if (c[CRC_W-1]) begin
				c = {c[CRC_W-2:0], 1'b0} ^ poly;
			end else begin
				c = {c[CRC_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== hdl/stx_stuffed_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// stx_stuffed_packet_deframer
// Receives raw serial bytes, removes doubled stx stuffing, tracks the frame
// layout and checks address and crc-16, one result item per input byte.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  in       | in_valid / in_ready  | rx_byte
//  out      | out_valid / out_ready| content_*, restarted, frame_*, seq_bit,
//           |                      | payload_len
//  cfg      | cfg_wr_en            | cfg_index, cfg_data
//
//  a result is registered: an accepted item enters the input register, then
//  the frame logic and crc step write its result into the result register
//  one item per cycle is sustained unless a stalled result holds the pipe;
//  one more item then waits in the input register; the 8-bit crc step is the
//  longest path; reset clears frame state and loads the register defaults
// ----------------------------------------------------------------------------
module stx_stuffed_packet_deframer #(
	parameter logic [spd_pkg::BYTE_W-1:0] START_BYTE = spd_pkg::START_BYTE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            cfg_wr_en,
	input  logic [spd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [spd_pkg::CFG_W-1:0]       cfg_data,

	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [spd_pkg::BYTE_W-1:0]      rx_byte,

	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            content_valid,
	output logic [spd_pkg::BYTE_W-1:0]      content_byte,
	output logic [spd_pkg::POS_W-1:0]       content_pos,
	output logic                            restarted,
	output logic                            frame_end,
	output logic [1:0]                      frame_status,
	output logic                            seq_bit,
	output logic [spd_pkg::BYTE_W-1:0]      payload_len
);
	import spd_pkg::*;

	// configuration
	logic [ADDR_W-1:0] dev_addr_q;
	logic [CRC_W-1:0]  crc_seed_q;
	logic [CRC_W-1:0]  crc_poly_q;

	// input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// frame state
	logic [POS_W-1:0]  pos_q;
	logic              len_known_q;
	logic              stuff_q;
	logic [CRC_W-1:0]  crc_q;
	logic [BYTE_W-1:0] addr_byte_q;
	logic [BYTE_W-1:0] len_byte_q;
	logic [BYTE_W-1:0] crc_low_q;

	logic advance;

	// next-state and result logic
	logic              is_stx;
	logic              do_add;
	logic              restart;
	logic [POS_W-1:0]  p_eff;
	logic [CRC_W-1:0]  crc_eff;
	logic              lk_eff;
	logic [CRC_W-1:0]  crc_step;
	logic [POS_W-1:0]  p_inc;
	logic [POS_W-1:0]  crc_end_pos;
	logic [POS_W-1:0]  total;
	logic              ends;
	frame_status_t     status;

	logic [POS_W-1:0]  pos_d;
	logic              len_known_d;
	logic              stuff_d;
	logic [CRC_W-1:0]  crc_d;
	logic [BYTE_W-1:0] addr_byte_d;
	logic [BYTE_W-1:0] len_byte_d;
	logic [BYTE_W-1:0] crc_low_d;

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= DEV_ADDR_RST;
			crc_seed_q <= CRC_SEED_RST;
			crc_poly_q <= CRC_POLY_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DEV_ADDR: dev_addr_q <= cfg_data[ADDR_W-1:0];
				REG_CRC_SEED: crc_seed_q <= cfg_data[CRC_W-1:0];
				REG_CRC_POLY: crc_poly_q <= cfg_data[CRC_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	always_comb begin
		is_stx      = (byte_s1 == START_BYTE);
		restart     = 1'b0;
		do_add      = 1'b0;
		p_eff       = pos_q;
		crc_eff     = crc_q;
		lk_eff      = len_known_q;

		pos_d       = pos_q;
		len_known_d = len_known_q;
		stuff_d     = stuff_q;
		crc_d       = crc_q;
		addr_byte_d = addr_byte_q;
		len_byte_d  = len_byte_q;
		crc_low_d   = crc_low_q;

		if (pos_q == '0) begin
			if (is_stx) begin
				pos_d       = POS_ADDR;
				crc_d       = crc_seed_q;
				len_known_d = 1'b0;
				stuff_d     = 1'b0;
			end
		end else if (stuff_q) begin
			stuff_d = 1'b0;
			do_add  = 1'b1;
			if (!is_stx) begin
				restart = 1'b1;
				p_eff   = POS_ADDR;
				crc_eff = crc_seed_q;
				lk_eff  = 1'b0;
			end
		end else if (is_stx) begin
			stuff_d = 1'b1;
		end else begin
			do_add = 1'b1;
		end

		crc_step    = crc_update(crc_eff, byte_s1, crc_poly_q);
		p_inc       = p_eff + 9'd1;
		crc_end_pos = {1'b0, len_byte_q} + HEADER_LEN;
		total       = {1'b0, len_byte_q} + FRAME_OVERHEAD;
		ends        = do_add && lk_eff && (p_inc == total);

		if ((addr_byte_q[ADDR_W-1:0]) != dev_addr_q) begin
			status = FS_WRONG_ADDR;
		end else if (crc_low_q == crc_eff[7:0] && byte_s1 == crc_eff[15:8]) begin
			status = FS_OK;
		end else begin
			status = FS_BAD_CRC;
		end

		if (do_add) begin
			pos_d       = p_inc;
			crc_d       = crc_eff;
			len_known_d = lk_eff;
			if (p_eff == POS_ADDR) begin
				addr_byte_d = byte_s1;
				crc_d       = crc_step;
			end else if (p_eff == POS_LEN) begin
				len_byte_d  = byte_s1;
				len_known_d = 1'b1;
				crc_d       = crc_step;
			end else if (lk_eff && p_eff < crc_end_pos) begin
				crc_d = crc_step;
			end else if (lk_eff && p_eff == crc_end_pos) begin
				crc_low_d = byte_s1;
			end
			if (ends) begin
				pos_d       = '0;
				stuff_d     = 1'b0;
				len_known_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			len_known_q <= 1'b0;
			stuff_q     <= 1'b0;
			crc_q       <= CRC_SEED_RST;
			addr_byte_q <= '0;
			len_byte_q  <= '0;
			crc_low_q   <= '0;
		end else if (advance) begin
			pos_q       <= pos_d;
			len_known_q <= len_known_d;
			stuff_q     <= stuff_d;
			crc_q       <= crc_d;
			addr_byte_q <= addr_byte_d;
			len_byte_q  <= len_byte_d;
			crc_low_q   <= crc_low_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			content_valid <= do_add;
			content_byte  <= do_add ? byte_s1 : '0;
			content_pos   <= do_add ? p_eff : '0;
			restarted     <= restart;
			frame_end     <= ends;
			frame_status  <= ends ? status : FS_OK;
			seq_bit       <= ends ? addr_byte_q[BYTE_W-1] : 1'b0;
			payload_len   <= ends ? len_byte_q : '0;
		end
	end

	a_stuff_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		stuff_q |-> (pos_q != '0))
		else $error("stuff pending outside a frame");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_MAX)
		else $error("frame position out of range");

	a_restart_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && restarted) |-> (content_valid && content_pos == POS_ADDR))
		else $error("restart not reported at address position");

	a_end_content: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_end) |-> (content_valid && content_pos >= FRAME_OVERHEAD - 9'd1))
		else $error("frame end without final content byte");

	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && ends) |=> (pos_q == '0 && !stuff_q && !len_known_q))
		else $error("frame state not cleared at frame end");

endmodule
